// ===== rtl/core/vertex_component_to_float_convert_top_defines.svh =====
// assertion macros used by the checker file vcf_checker.sv
`ifndef VERTEX_COMPONENT_TO_FLOAT_CONVERT_TOP_DEFINES_SVH
`define VERTEX_COMPONENT_TO_FLOAT_CONVERT_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vcf_pkg.sv =====
// shared types and constants of the vertex component converter
`default_nettype none
package vcf_pkg;

    localparam int RawW   = 32;
    localparam int FloatW = 32;
    localparam int IdxW   = 16;
    localparam int KindW  = 3;
    localparam int CfgW   = 3;
    localparam int StrW   = 64;
    localparam int ShW    = 6;
    localparam int ExpW   = 8;
    localparam int OutW   = 56;

    localparam logic [KindW-1:0] KIND_INT8    = 3'd0;
    localparam logic [KindW-1:0] KIND_UINT8   = 3'd1;
    localparam logic [KindW-1:0] KIND_INT16   = 3'd2;
    localparam logic [KindW-1:0] KIND_UINT16  = 3'd3;
    localparam logic [KindW-1:0] KIND_UINT32  = 3'd4;
    localparam logic [KindW-1:0] KIND_FLOAT32 = 3'd5;

    localparam logic CFG_KIND = 1'b0;
    localparam logic CFG_NORM = 1'b1;

    localparam logic [FloatW-1:0] FLOAT_ONE = 32'h3F80_0000;
    localparam logic [ExpW-1:0]   EXP_BIAS  = 8'd127;

    typedef enum logic [2:0] {
        MODE_ZERO,
        MODE_PASS,
        MODE_INT,
        MODE_RATIO,
        MODE_ONE
    } mode_t;

    // decode stage result
    typedef struct packed {
        mode_t             mode;
        logic              neg;
        logic              sgn;
        logic              wide;
        logic [RawW-1:0]   mag;
        logic [IdxW-1:0]   idx;
        logic              bad;
    } dec_t;

    // normalize stage result
    typedef struct packed {
        mode_t             mode;
        logic              neg;
        logic [StrW-1:0]   word;
        logic [ShW-1:0]    shift;
        logic [ExpW-1:0]   expo;
        logic [RawW-1:0]   raw;
        logic [IdxW-1:0]   idx;
        logic              bad;
    } nrm_t;

endpackage
`default_nettype wire

// ===== rtl/core/vertex_component_to_float_convert_top.sv =====
// top level of the vertex component to float converter
//
//  channel  | direction | word contents (lowest bit up)
//  s_*      | in        | raw_component[31:0]
//  m_*      | out       | float_bits[31:0], index_value[47:32], index_incompatible[48]
//  cfg_*    | in        | addr 0 component_kind, addr 1 normalize_enable
//
// three register stages: decode, leading one search, align and round
// one word per cycle while not stalled; m_tvalid rises once the round stage holds the word
// the three stages advance together while the output register is empty or taken
// reset clears stage valids, kind resets to float32, normalize off
`default_nettype none
module vertex_component_to_float_convert_top
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [vcf_pkg::RawW-1:0]    s_tdata,   // raw_component
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [vcf_pkg::OutW-1:0]         m_tdata,   // float_bits, index_value, index_incompatible
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_addr,
    input  wire logic [vcf_pkg::CfgW-1:0]    cfg_wdata
);

    logic [vcf_pkg::KindW-1:0] kind_reg;
    logic                      norm_reg;
    logic                      adv;
    logic                      v1;
    logic                      v2;
    vcf_pkg::dec_t             dec;
    vcf_pkg::nrm_t             nrm;

    // whole pipe moves when the output slot frees up
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= vcf_pkg::KIND_FLOAT32;
            norm_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                vcf_pkg::CFG_KIND: kind_reg <= cfg_wdata;
                vcf_pkg::CFG_NORM: norm_reg <= cfg_wdata[0];
                default:           kind_reg <= kind_reg;
            endcase
        end
    end

    vcf_decode u_dec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .raw       (s_tdata),
        .kind      (kind_reg),
        .norm      (norm_reg),
        .valid_reg (v1),
        .dec_reg   (dec)
    );

    vcf_norm u_nrm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v1),
        .dec       (dec),
        .valid_reg (v2),
        .nrm_reg   (nrm)
    );

    vcf_round u_rnd
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v2),
        .nrm       (nrm),
        .valid_reg (m_tvalid),
        .data_reg  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/core/vcf_decode.sv =====
// stage one: kind decode, magnitude and index path
`default_nettype none
module vcf_decode
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [vcf_pkg::RawW-1:0]  raw,
    input  wire logic [vcf_pkg::KindW-1:0] kind,
    input  wire logic                      norm,
    output logic                           valid_reg,
    output vcf_pkg::dec_t                  dec_reg
);

    vcf_pkg::dec_t dec_next;
    logic [7:0]    m8;
    logic [15:0]   m16;

    always_comb
    begin
        m8  = 8'(~raw[7:0] + 8'd1);
        m16 = 16'(~raw[15:0] + 16'd1);
        dec_next      = '0;
        dec_next.mode = vcf_pkg::MODE_ZERO;
        dec_next.bad  = 1'b1;
        case (kind)
            vcf_pkg::KIND_INT8:
            begin
                dec_next.neg  = raw[7];
                dec_next.sgn  = 1'b1;
                dec_next.mag  = {24'd0, raw[7] ? m8 : raw[7:0]};
                dec_next.mode = norm ? vcf_pkg::MODE_RATIO : vcf_pkg::MODE_INT;
                if (norm && dec_next.mag >= 32'd127)
                    dec_next.mode = vcf_pkg::MODE_ONE;
            end
            vcf_pkg::KIND_UINT8:
            begin
                dec_next.mag  = {24'd0, raw[7:0]};
                dec_next.mode = norm ? vcf_pkg::MODE_RATIO : vcf_pkg::MODE_INT;
                if (norm && raw[7:0] == 8'hFF)
                    dec_next.mode = vcf_pkg::MODE_ONE;
                dec_next.idx  = {8'd0, raw[7:0]};
                dec_next.bad  = 1'b0;
            end
            vcf_pkg::KIND_INT16:
            begin
                dec_next.neg  = raw[15];
                dec_next.sgn  = 1'b1;
                dec_next.wide = 1'b1;
                dec_next.mag  = {16'd0, raw[15] ? m16 : raw[15:0]};
                dec_next.mode = norm ? vcf_pkg::MODE_RATIO : vcf_pkg::MODE_INT;
                if (norm && dec_next.mag >= 32'd32767)
                    dec_next.mode = vcf_pkg::MODE_ONE;
            end
            vcf_pkg::KIND_UINT16:
            begin
                dec_next.wide = 1'b1;
                dec_next.mag  = {16'd0, raw[15:0]};
                dec_next.mode = norm ? vcf_pkg::MODE_RATIO : vcf_pkg::MODE_INT;
                if (norm && raw[15:0] == 16'hFFFF)
                    dec_next.mode = vcf_pkg::MODE_ONE;
                dec_next.idx  = raw[15:0];
                dec_next.bad  = 1'b0;
            end
            vcf_pkg::KIND_UINT32:
            begin
                dec_next.mag  = raw;
                dec_next.mode = vcf_pkg::MODE_INT;
                dec_next.idx  = raw[15:0];
                dec_next.bad  = (raw[31:16] != 16'd0);
            end
            vcf_pkg::KIND_FLOAT32:
            begin
                dec_next.mag  = raw;
                dec_next.mode = vcf_pkg::MODE_PASS;
            end
            default:
            begin
                dec_next.mode = vcf_pkg::MODE_ZERO;
            end
        endcase
        // zero magnitude always gives positive zero
        if ((dec_next.mode == vcf_pkg::MODE_INT || dec_next.mode == vcf_pkg::MODE_RATIO)
            && dec_next.mag == '0)
            dec_next.mode = vcf_pkg::MODE_ZERO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dec_reg <= dec_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/vcf_norm.sv =====
// stage two: leading one search, bit stream and exponent
`default_nettype none
module vcf_norm
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire vcf_pkg::dec_t dec,
    output logic               valid_reg,
    output vcf_pkg::nrm_t      nrm_reg
);

    vcf_pkg::nrm_t nrm_next;
    logic [4:0]    pos;
    logic [69:0]   rep7;
    logic [74:0]   rep15;

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < vcf_pkg::RawW; i++)
        begin
            if (dec.mag[i])
                pos = 5'(i);
        end
        rep7  = {10{dec.mag[6:0]}};
        rep15 = {5{dec.mag[14:0]}};
        nrm_next      = '0;
        nrm_next.mode = dec.mode;
        nrm_next.neg  = dec.neg;
        nrm_next.raw  = dec.mag;
        nrm_next.idx  = dec.idx;
        nrm_next.bad  = dec.bad;
        if (dec.mode == vcf_pkg::MODE_RATIO)
        begin
            // n / (2^w - 1) is the w-bit pattern of n repeated forever,
            // laid out from bit 63 down starting on a pattern boundary
            if (dec.wide && dec.sgn)
            begin
                nrm_next.word  = rep15[74:11];
                nrm_next.shift = 6'(5'd14 - pos);
                nrm_next.expo  = vcf_pkg::EXP_BIAS + 8'(pos) - 8'd15;
            end
            else if (dec.wide)
            begin
                nrm_next.word  = {4{dec.mag[15:0]}};
                nrm_next.shift = 6'(5'd15 - pos);
                nrm_next.expo  = vcf_pkg::EXP_BIAS + 8'(pos) - 8'd16;
            end
            else if (dec.sgn)
            begin
                nrm_next.word  = rep7[69:6];
                nrm_next.shift = 6'(5'd6 - pos);
                nrm_next.expo  = vcf_pkg::EXP_BIAS + 8'(pos) - 8'd7;
            end
            else
            begin
                nrm_next.word  = {8{dec.mag[7:0]}};
                nrm_next.shift = 6'(5'd7 - pos);
                nrm_next.expo  = vcf_pkg::EXP_BIAS + 8'(pos) - 8'd8;
            end
        end
        else
        begin
            nrm_next.word  = {dec.mag, 32'd0};
            nrm_next.shift = 6'(5'd31 - pos);
            nrm_next.expo  = vcf_pkg::EXP_BIAS + 8'(pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            nrm_reg <= nrm_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/vcf_round.sv =====
// stage three: align, round to nearest even, pack the output word
`default_nettype none
module vcf_round
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     adv,
    input  wire logic                     in_valid,
    input  wire vcf_pkg::nrm_t            nrm,
    output logic                          valid_reg,
    output logic [vcf_pkg::OutW-1:0]      data_reg
);

    logic [vcf_pkg::StrW-1:0]   al;
    logic [24:0]                sum;
    logic                       up;
    logic [vcf_pkg::FloatW-1:0] fbits;

    always_comb
    begin
        // leading one lands on bit 63, the repeated pattern still fills the sticky bits
        al  = nrm.word << nrm.shift;
        up  = al[39] & ((|al[38:0]) | al[40]);
        sum = {1'b0, al[63:40]} + 25'(up);
        case (nrm.mode)
            vcf_pkg::MODE_PASS:  fbits = nrm.raw;
            vcf_pkg::MODE_ONE:   fbits = vcf_pkg::FLOAT_ONE | {nrm.neg, 31'd0};
            vcf_pkg::MODE_INT,
            vcf_pkg::MODE_RATIO: fbits = {nrm.neg, nrm.expo + 8'(sum[24]), sum[22:0]};
            default:             fbits = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= {7'd0, nrm.bad, nrm.idx, fbits};
    end

endmodule
`default_nettype wire

// ===== rtl/core/vcf_checker.sv =====
// port-level checker for the converter, bound to the top level
`default_nettype none
`include "vertex_component_to_float_convert_top_defines.svh"
module vcf_checker
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tready,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic [vcf_pkg::OutW-1:0] m_tdata
);

    `VCF_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "output word dropped")
    `VCF_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "stalled word changed")
    `VCF_ASSERT_NOW(a_ready, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready mismatch")
    `VCF_ASSERT_NOW(a_pad, m_tvalid, m_tdata[55:49] == 7'd0, "pad bits not zero")

endmodule

bind vertex_component_to_float_convert_top vcf_checker u_chk (.*);
`default_nettype wire
